/* rtl/bal_pkg.sv */
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants of the bounded array list engine: field widths,
// command and status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int DEF_STORE_DEPTH = 256;
    localparam int DEF_WORD_BITS   = 32;

    localparam int CMD_BITS  = 3;
    localparam int POS_BITS  = 8;
    localparam int OPND_BITS = 32;
    localparam int RES_BITS  = 32;
    localparam int STAT_BITS = 2;
    localparam int CNT_BITS  = 9;
    localparam int CAP_BITS  = 9;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd100;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_APPEND      = 3'd0,
        CMD_READ        = 3'd1,
        CMD_WRITE       = 3'd2,
        CMD_REMOVE_LAST = 3'd3,
        CMD_REMOVE_AT   = 3'd4,
        CMD_INSERT_AT   = 3'd5,
        CMD_FIND_FIRST  = 3'd6,
        CMD_FIND_LAST   = 3'd7
    } t_cmd;

    typedef enum logic [STAT_BITS-1:0] {
        ST_DONE   = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DELIVER
    } t_state;

    typedef enum logic [2:0] {
        W_READ,
        W_LSHIFT,
        W_RSHIFT,
        W_FFIRST,
        W_FLAST
    } t_walk;

    typedef struct packed {
        logic latch;
        logic exec;
        logic step;
        logic finish;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic walk_start;
        logic walk_done;
    } t_dp_stat;

endpackage

/* rtl/bal_in_if.sv */
// ----------------------------------------------------------------------------
// bal_in_if
// Request channel of the list engine: one list command per request.
// ----------------------------------------------------------------------------
interface bal_in_if;
    logic                                valid;
    logic                                ready;
    logic [bal_pkg::CMD_BITS-1:0]        cmd;
    logic [bal_pkg::POS_BITS-1:0]        position;
    logic signed [bal_pkg::OPND_BITS-1:0] operand_value;

    modport source (output valid, output cmd, output position, output operand_value,
                    input ready);
    modport sink   (input valid, input cmd, input position, input operand_value,
                    output ready);
endinterface

/* rtl/bal_out_if.sv */
// ----------------------------------------------------------------------------
// bal_out_if
// Result channel of the list engine: one result per command.
// ----------------------------------------------------------------------------
interface bal_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bal_pkg::RES_BITS-1:0] result_word;
    logic [bal_pkg::STAT_BITS-1:0]       status;
    logic [bal_pkg::CNT_BITS-1:0]        entry_count;

    modport source (output valid, output result_word, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input result_word, input status, input entry_count,
                    output ready);
endinterface

/* rtl/bal_ctrl.sv */
// ----------------------------------------------------------------------------
// bal_ctrl
// Sequencer of the list engine: takes a request, runs the decode cycle, steps
// the store walk and hands the result to the output register.
// ----------------------------------------------------------------------------
module bal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  bal_pkg::t_dp_stat i_stat,
    output bal_pkg::t_ctl_cmd o_cmd
);
    import bal_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.walk_start ? S_WALK : S_DELIVER;
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_stat.walk_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DELIVER;
                end
            end
            S_DELIVER: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/bal_dpath.sv */
// ----------------------------------------------------------------------------
// bal_dpath
// Datapath of the list engine: entry store, count and capacity registers,
// command decode, the walk pointer with its pipelined store read, and the
// output register.
// ----------------------------------------------------------------------------
module bal_dpath #(
    parameter int STORE_DEPTH = bal_pkg::DEF_STORE_DEPTH,
    parameter int WORD_BITS   = bal_pkg::DEF_WORD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bal_pkg::CAP_BITS-1:0]         i_cfg_wdata,
    input  logic [bal_pkg::CMD_BITS-1:0]         i_cmd,
    input  logic [bal_pkg::POS_BITS-1:0]         i_position,
    input  logic signed [bal_pkg::OPND_BITS-1:0] i_operand,
    input  bal_pkg::t_ctl_cmd                    i_ctl,
    output bal_pkg::t_dp_stat                    o_stat,
    output logic signed [bal_pkg::RES_BITS-1:0]  o_result_word,
    output logic [bal_pkg::STAT_BITS-1:0]        o_status,
    output logic [bal_pkg::CNT_BITS-1:0]         o_entry_count
);
    import bal_pkg::*;

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int XW0 = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam int XW  = (XW0 > POS_BITS) ? XW0 : POS_BITS + 1;

    logic [WORD_BITS-1:0]       r_mem [STORE_DEPTH];
    logic [WORD_BITS-1:0]       r_rdata;

    logic [CAP_BITS-1:0]        r_cap;
    t_cmd                       r_cmd;
    logic [POS_BITS-1:0]        r_pos;
    logic [WORD_BITS-1:0]       r_val;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    t_walk                      r_walk;
    logic [AW-1:0]              r_ptr;
    logic [CW-1:0]              r_left;
    logic [AW-1:0]              r_tag;
    logic                       r_pend;
    logic                       r_hit;
    logic signed [RES_BITS-1:0] r_word;
    t_status                    r_status;
    logic signed [RES_BITS-1:0] r_o_word;
    t_status                    r_o_status;
    logic [CNT_BITS-1:0]        r_o_count;

    logic [XW-1:0]              cnt_x;
    logic [XW-1:0]              pos_x;
    logic [XW-1:0]              cap_x;
    logic [XW-1:0]              cap_use;
    logic [AW-1:0]              pos_a;
    logic [AW-1:0]              cnt_a;
    logic                       full;
    logic                       in_range;

    logic                       d_start;
    t_walk                      d_walk;
    logic [AW-1:0]              d_ptr;
    logic [CW-1:0]              d_left;
    logic signed [RES_BITS-1:0] d_word;
    t_status                    d_status;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [WORD_BITS-1:0]       wr_data;
    logic                       rd_en;
    logic                       issue;
    logic                       take;
    logic                       is_find;
    logic                       hit_now;
    logic                       walk_down;

    assign cnt_x    = XW'(r_count);
    assign pos_x    = XW'(r_pos);
    assign cap_x    = XW'(r_cap);
    assign cap_use  = (cap_x > XW'(STORE_DEPTH)) ? XW'(STORE_DEPTH) : cap_x;
    assign full     = cnt_x >= cap_use;
    assign in_range = pos_x < cnt_x;
    assign pos_a    = AW'(r_pos);
    assign cnt_a    = AW'(r_count);

    // command decode, used in the execute cycle
    always_comb begin
        d_start  = 1'b0;
        d_walk   = W_READ;
        d_ptr    = pos_a;
        d_left   = '0;
        d_word   = '0;
        d_status = ST_DONE;
        case (r_cmd)
            CMD_APPEND: begin
                if (full) begin
                    d_status = ST_FULL;
                end
            end
            CMD_READ: begin
                if (in_range) begin
                    d_start = 1'b1;
                    d_walk  = W_READ;
                    d_left  = CW'(1);
                end else begin
                    d_word   = '1;
                    d_status = ST_RANGE;
                end
            end
            CMD_WRITE: begin
                if (!in_range) begin
                    d_status = ST_RANGE;
                end
            end
            CMD_REMOVE_LAST: begin
                if (r_count == '0) begin
                    d_status = ST_RANGE;
                end
            end
            CMD_REMOVE_AT: begin
                if (in_range) begin
                    d_start = 1'b1;
                    d_walk  = W_LSHIFT;
                    d_ptr   = pos_a + AW'(1);
                    d_left  = CW'(cnt_x - pos_x - XW'(1));
                end else begin
                    d_status = ST_RANGE;
                end
            end
            CMD_INSERT_AT: begin
                if (pos_x > cnt_x) begin
                    d_status = ST_RANGE;
                end else if (&r_val) begin
                    d_status = ST_REJECT;
                end else if (full) begin
                    d_status = ST_FULL;
                end else begin
                    d_start = 1'b1;
                    d_walk  = W_RSHIFT;
                    d_ptr   = cnt_a - AW'(1);
                    d_left  = CW'(cnt_x - pos_x);
                end
            end
            CMD_FIND_FIRST: begin
                d_word  = '1;
                d_start = 1'b1;
                d_walk  = W_FFIRST;
                d_ptr   = '0;
                d_left  = r_count;
            end
            CMD_FIND_LAST: begin
                d_word  = '1;
                d_start = 1'b1;
                d_walk  = W_FLAST;
                d_ptr   = cnt_a - AW'(1);
                d_left  = r_count;
            end
            default: begin
                d_status = ST_DONE;
            end
        endcase
    end

    assign is_find   = (r_walk == W_FFIRST) || (r_walk == W_FLAST);
    assign walk_down = (r_walk == W_RSHIFT) || (r_walk == W_FLAST);
    assign issue     = i_ctl.step && (r_left != '0) && !r_hit;
    assign take      = i_ctl.step && r_pend && !r_hit;
    assign hit_now   = take && is_find && (r_rdata == r_val);

    // store write port and count update
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_a;
        wr_data = r_val;
        rd_en   = issue;
        n_count = r_count;
        if (i_ctl.exec) begin
            case (r_cmd)
                CMD_APPEND: begin
                    if (!full) begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_a;
                        n_count = r_count + CW'(1);
                    end
                end
                CMD_WRITE: begin
                    wr_en = in_range;
                end
                CMD_REMOVE_LAST: begin
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
        if (take) begin
            case (r_walk)
                W_LSHIFT: begin
                    wr_en   = 1'b1;
                    wr_addr = r_tag - AW'(1);
                    wr_data = r_rdata;
                end
                W_RSHIFT: begin
                    wr_en   = 1'b1;
                    wr_addr = r_tag + AW'(1);
                    wr_data = r_rdata;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
        if (i_ctl.finish) begin
            case (r_walk)
                W_LSHIFT: begin
                    n_count = r_count - CW'(1);
                end
                W_RSHIFT: begin
                    wr_en   = 1'b1;
                    wr_addr = pos_a;
                    wr_data = r_val;
                    n_count = r_count + CW'(1);
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (i_ctl.exec) begin
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
            end else if (i_ctl.step) begin
                r_pend <= issue;
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd <= t_cmd'(i_cmd);
            r_pos <= i_position;
            r_val <= WORD_BITS'(i_operand);
        end
        if (i_ctl.exec) begin
            r_walk   <= d_walk;
            r_ptr    <= d_ptr;
            r_left   <= d_left;
            r_word   <= d_word;
            r_status <= d_status;
        end else if (i_ctl.step) begin
            if (issue) begin
                r_ptr  <= walk_down ? r_ptr - AW'(1) : r_ptr + AW'(1);
                r_left <= r_left - CW'(1);
                r_tag  <= r_ptr;
            end
            if (take && (r_walk == W_READ)) begin
                r_word <= RES_BITS'($signed(r_rdata));
            end
            if (hit_now) begin
                r_word <= RES_BITS'(r_tag);
            end
        end
        if (i_ctl.load_out) begin
            r_o_word   <= r_word;
            r_o_status <= r_status;
            r_o_count  <= CNT_BITS'(r_count);
        end
    end

    assign o_stat.walk_start = d_start;
    assign o_stat.walk_done  = r_hit || ((r_left == '0) && !r_pend);
    assign o_result_word     = r_o_word;
    assign o_status          = r_o_status;
    assign o_entry_count     = r_o_count;

endmodule

/* rtl/bounded_array_list_engine.sv */
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Bounded, densely packed list of signed words with append, read, write,
// remove, insert with shift, and find first/last commands.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        cmd, position, operand_value
//   o_out     out  valid/ready        result_word, status, entry_count
//   i_cfg     in   i_cfg_we           i_cfg_wdata (list capacity)
//
// Append, write, remove last and rejected commands return without a store walk;
// read walks one entry; remove at, insert at and find walk the entries they
// shift or search, up to a full store (one entry a cycle).
// Reset clears the count and sets capacity to 100; the store is not cleared.
// A request is taken while an earlier result waits in the output register;
// a stalled result holds the block in its last cycle.
// ----------------------------------------------------------------------------
module bounded_array_list_engine #(
    parameter int STORE_DEPTH = bal_pkg::DEF_STORE_DEPTH,
    parameter int WORD_BITS   = bal_pkg::DEF_WORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bal_in_if.sink                       i_in,
    bal_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [bal_pkg::CAP_BITS-1:0] i_cfg_wdata
);
    import bal_pkg::*;

    t_ctl_cmd s_ctl;
    t_dp_stat s_stat;

    bal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (s_stat),
        .o_cmd       (s_ctl)
    );

    bal_dpath #(
        .STORE_DEPTH (STORE_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_in.cmd),
        .i_position    (i_in.position),
        .i_operand     (i_in.operand_value),
        .i_ctl         (s_ctl),
        .o_stat        (s_stat),
        .o_result_word (o_out.result_word),
        .o_status      (o_out.status),
        .o_entry_count (o_out.entry_count)
    );

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while a command is still in progress");

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctl.load_out |-> (!o_out.valid || o_out.ready))
        else $error("result loaded over an undelivered result");

    a_count_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (int'(o_out.entry_count) <= STORE_DEPTH))
        else $error("entry count beyond store depth");

    a_walk_only_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctl.finish |-> s_ctl.step)
        else $error("walk finished outside a walk step");

endmodule

/* sim/list_engine_scoreboard.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_engine_scoreboard
// Watches the request, result and capacity ports of the list engine, keeps
// its own copy of the list and the capacity, works out the outcome of every
// accepted request and compares each accepted result, field by field, with
// the oldest outcome still awaited.
// ----------------------------------------------------------------------------
module list_engine_scoreboard
    import bal_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    bal_in_if                   i_req,
    bal_out_if                  i_rsp,
    input  logic                i_cfg_we,
    input  logic [CAP_BITS-1:0] i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    typedef struct packed {
        logic [RES_BITS-1:0] word;
        t_status             status;
        logic [CNT_BITS-1:0] count;
    } t_list_outcome;

    logic [OPND_BITS-1:0] list_words [DEF_STORE_DEPTH];
    int unsigned          list_len;
    int unsigned          list_cap;
    t_list_outcome        awaited_outcomes [$];
    int                   failures;
    int                   checked;

    initial begin
        failures     = 0;
        checked      = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic t_list_outcome list_command_outcome(input t_cmd c,
                                                           input logic [POS_BITS-1:0] pos,
                                                           input logic [OPND_BITS-1:0] val);
        t_list_outcome r;
        int unsigned   lim;
        int            i;
        bit            hit;
        r.word   = '0;
        r.status = ST_DONE;
        hit      = 1'b0;
        lim      = (list_cap > DEF_STORE_DEPTH) ? DEF_STORE_DEPTH : list_cap;
        case (c)
            CMD_APPEND: begin
                if (list_len < lim) begin
                    list_words[list_len] = val;
                    list_len++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            CMD_READ: begin
                if (pos < list_len) begin
                    r.word = list_words[pos];
                end else begin
                    r.word   = '1;
                    r.status = ST_RANGE;
                end
            end
            CMD_WRITE: begin
                if (pos < list_len) list_words[pos] = val;
                else r.status = ST_RANGE;
            end
            CMD_REMOVE_LAST: begin
                if (list_len > 0) list_len--;
                else r.status = ST_RANGE;
            end
            CMD_REMOVE_AT: begin
                if (pos < list_len) begin
                    for (i = pos; i + 1 < int'(list_len); i++) list_words[i] = list_words[i + 1];
                    list_len--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            CMD_INSERT_AT: begin
                if (pos > list_len) begin
                    r.status = ST_RANGE;
                end else if (val == '1) begin
                    r.status = ST_REJECT;
                end else if (list_len >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = int'(list_len); i > int'(pos); i--) list_words[i] = list_words[i - 1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            CMD_FIND_FIRST: begin
                r.word = '1;
                for (i = 0; i < int'(list_len) && !hit; i++) begin
                    if (list_words[i] == val) begin
                        r.word = i;
                        hit    = 1'b1;
                    end
                end
            end
            CMD_FIND_LAST: begin
                r.word = '1;
                for (i = int'(list_len) - 1; i >= 0 && !hit; i--) begin
                    if (list_words[i] == val) begin
                        r.word = i;
                        hit    = 1'b1;
                    end
                end
            end
        endcase
        r.count = list_len[CNT_BITS-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_list_outcome want;
        if (!i_rst_n) begin
            list_len = 0;
            list_cap = CAP_RESET;
            awaited_outcomes.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result: expected none, actual word %h status %0d count %0d",
                             $time, i_rsp.result_word, i_rsp.status, i_rsp.entry_count);
                end else begin
                    want = awaited_outcomes.pop_front();
                    checked++;
                    if (i_rsp.result_word !== want.word) begin
                        failures++;
                        $display("%0t: result_word expected %h, actual %h",
                                 $time, want.word, i_rsp.result_word);
                    end
                    if (i_rsp.status !== want.status) begin
                        failures++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, i_rsp.status);
                    end
                    if (i_rsp.entry_count !== want.count) begin
                        failures++;
                        $display("%0t: entry_count expected %0d, actual %0d",
                                 $time, want.count, i_rsp.entry_count);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_outcomes.push_back(list_command_outcome(t_cmd'(i_req.cmd),
                                                                i_req.position,
                                                                i_req.operand_value));
            end
            if (i_cfg_we) list_cap = i_cfg_wdata;
        end
        o_fail_count <= failures;
        o_pending    <= awaited_outcomes.size();
        o_checked    <= checked;
    end

endmodule

/* sim/tb_bounded_array_list_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_array_list_engine
// Drives list commands into the engine: a directed pass over the empty, full
// and rejected cases, then random command mixes under several capacities
// with sender gaps and receiver stalls. The scoreboard beside the engine
// checks every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bounded_array_list_engine;
    import bal_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 270;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CAP_BITS-1:0] cfg_wdata;

    bal_in_if  req_if ();
    bal_out_if rsp_if ();

    int send_idle_pct;
    int recv_stall_pct;
    int cap_limit;
    int requests_sent;
    int settings_used;
    int quiet_cycles;
    int fail_count;
    int pending_count;
    int checked_count;

    bounded_array_list_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if),
        .o_out       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    list_engine_scoreboard scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_request(input t_cmd c, input logic [POS_BITS-1:0] p,
                                input logic [OPND_BITS-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.cmd           <= c;
        req_if.position      <= p;
        req_if.operand_value <= v;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic settle_block();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_capacity(input int v);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[CAP_BITS-1:0];
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cap_limit = (v > DEF_STORE_DEPTH) ? DEF_STORE_DEPTH : v;
        settings_used++;
    endtask

    task automatic random_request();
        t_cmd                 c;
        logic [POS_BITS-1:0]  p;
        logic [OPND_BITS-1:0] v;
        int                   roll;
        roll = $urandom_range(99);
        if (roll < 30)      c = CMD_APPEND;
        else if (roll < 40) c = CMD_INSERT_AT;
        else if (roll < 52) c = CMD_READ;
        else if (roll < 62) c = CMD_WRITE;
        else if (roll < 70) c = CMD_REMOVE_LAST;
        else if (roll < 80) c = CMD_REMOVE_AT;
        else if (roll < 90) c = CMD_FIND_FIRST;
        else                c = CMD_FIND_LAST;
        if ($urandom_range(3) != 0) p = 8'($urandom_range(cap_limit > 255 ? 255 : cap_limit));
        else p = 8'($urandom_range(255));
        if ($urandom_range(1) == 0) begin
            case ($urandom_range(9))
                6:       v = '1;
                7:       v = 32'h8000_0000;
                8:       v = 32'h7FFF_FFFF;
                9:       v = 32'($urandom_range(15));
                default: v = 32'($urandom_range(5));
            endcase
        end else begin
            v = $urandom();
        end
        push_request(c, p, v);
    endtask

    task automatic run_phase(input int cap, input int n, input int s_pct, input int r_pct);
        write_capacity(cap);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(199) == 0) settle_block();
            if (cap_limit <= 40 && $urandom_range(199) == 0) begin
                repeat (cap_limit + 2) push_request(CMD_REMOVE_LAST, 8'($urandom()), $urandom());
            end
            random_request();
        end
    endtask

    task automatic directed_requests();
        push_request(CMD_REMOVE_LAST, 8'd0,   32'd0);
        push_request(CMD_READ,        8'd0,   32'd0);
        push_request(CMD_WRITE,       8'd0,   32'h1234_5678);
        push_request(CMD_REMOVE_AT,   8'd0,   32'd0);
        push_request(CMD_FIND_FIRST,  8'd0,   32'd0);
        push_request(CMD_FIND_LAST,   8'd0,   32'd0);
        push_request(CMD_INSERT_AT,   8'd1,   32'd5);
        push_request(CMD_INSERT_AT,   8'd0,   32'hFFFF_FFFF);
        push_request(CMD_APPEND,      8'd255, 32'h8000_0000);
        push_request(CMD_APPEND,      8'd0,   32'h7FFF_FFFF);
        push_request(CMD_APPEND,      8'd0,   32'hFFFF_FFFF);
        push_request(CMD_INSERT_AT,   8'd0,   32'd0);
        push_request(CMD_INSERT_AT,   8'd4,   32'h7FFF_FFFF);
        push_request(CMD_READ,        8'd0,   32'd0);
        push_request(CMD_READ,        8'd4,   32'd0);
        push_request(CMD_READ,        8'd255, 32'd0);
        push_request(CMD_WRITE,       8'd1,   32'h5A5A_A5A5);
        push_request(CMD_FIND_FIRST,  8'd0,   32'h7FFF_FFFF);
        push_request(CMD_FIND_LAST,   8'd0,   32'h7FFF_FFFF);
        push_request(CMD_FIND_FIRST,  8'd0,   32'hFFFF_FFFF);
        push_request(CMD_REMOVE_AT,   8'd0,   32'd0);
        push_request(CMD_REMOVE_AT,   8'd3,   32'd0);
        push_request(CMD_REMOVE_AT,   8'd255, 32'd0);
        // shrink capacity below the held count
        write_capacity(1);
        push_request(CMD_APPEND,      8'd0,   32'd1);
        push_request(CMD_INSERT_AT,   8'd0,   32'hFFFF_FFFF);
        push_request(CMD_INSERT_AT,   8'd5,   32'hFFFF_FFFF);
        push_request(CMD_INSERT_AT,   8'd0,   32'd9);
    endtask

    initial begin : stimulus
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_if.valid         = 1'b0;
        req_if.cmd           = '0;
        req_if.position      = '0;
        req_if.operand_value = '0;
        rsp_if.ready         = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        cap_limit            = CAP_RESET;
        requests_sent        = 0;
        settings_used        = 1;
        quiet_cycles         = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_requests();

        run_phase(8,   250, 0,  0);
        run_phase(1,   100, 85, 0);
        run_phase(16,  250, 0,  85);
        run_phase(0,   50,  29, 29);
        run_phase(40,  150, 0,  0);
        run_phase(3,   150, 85, 0);
        run_phase(2,   100, 0,  85);

        // fill the whole store
        write_capacity(511);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (256) push_request(CMD_APPEND, 8'($urandom()), $urandom());
        run_phase(511, 80, 29, 29);
        run_phase(256, 60, 0,  0);

        settle_block();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d list commands over %0d capacity settings, with gaps and stalls.",
                 requests_sent, settings_used);
        $display("%0d results compared against the predicted list.", checked_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bal_pkg.sv
rtl/bal_in_if.sv
rtl/bal_out_if.sv
rtl/bal_ctrl.sv
rtl/bal_dpath.sv
rtl/bounded_array_list_engine.sv
sim/list_engine_scoreboard.sv
sim/tb_bounded_array_list_engine.sv
